// ===== rtl/arpt_pkg.sv =====
// ----------------------------------------------------------------------------
// arpt_pkg - shared types and constants for the auto-range percent tracker
// Holds the field widths, reset values, the controller state type and the
// command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package arpt_pkg;

  // field widths
  localparam int READ_W  = 20;  // signed reading, 4 fraction bits
  localparam int VAL_W   = 19;  // stored value after clamping, always >= 0
  localparam int PCT_W   = 7;   // percent result
  localparam int IDX_W   = 3;   // divider step index

  // default list depth
  localparam int DEF_LIST_DEPTH = 10;

  // reset values
  localparam logic [VAL_W-1:0] RESET_REJECT = 19'd16000;  // 1000.0
  localparam logic [VAL_W-1:0] RESET_LOW    = 19'd1600;   // 100.0
  localparam logic [VAL_W-1:0] RESET_HIGH   = 19'd0;

  // result constants
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd99;
  localparam logic [PCT_W-1:0] PCT_FLOOR = 7'd1;
  localparam logic [PCT_W-1:0] PCT_ZERO  = 7'd0;
  localparam int               PCT_SCALE = 100;

  // quotient bits produced by the restoring divider (quotient < 100)
  localparam int DIV_STEPS = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIFF,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;      // capture clamped reading
    logic             update;    // sorted insert into both lists, sums
    logic             diff;      // form scaled reading and spread
    logic             scale;     // multiply by 100, latch flags
    logic             div_step;  // one restoring divide step
    logic [IDX_W-1:0] div_idx;   // quotient bit of this step
    logic             out_load;  // move result into output register
  } dp_cmd_t;

endpackage

// ===== rtl/arpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpt_ctrl - sequencing controller for the auto-range percent tracker
// Steps one reading through capture, list update, difference, scaling and
// a seven-step divide, and owns the input stall and output valid flags.
// ----------------------------------------------------------------------------
module arpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output arpt_pkg::dp_cmd_t cmd
);
  import arpt_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.div_idx  = cnt_r;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = IDX_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        // wait until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

endmodule

// ===== rtl/arpt_dp.sv =====
// ----------------------------------------------------------------------------
// arpt_dp - datapath for the auto-range percent tracker
// Sorted low and high lists with running sums, the spread arithmetic, a
// restoring divider and the output payload register.
// ----------------------------------------------------------------------------
module arpt_dp #(
  parameter int LIST_DEPTH = arpt_pkg::DEF_LIST_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [arpt_pkg::VAL_W-1:0]   cfg_wdata,
  input  logic signed [arpt_pkg::READ_W-1:0] in_reading,
  input  arpt_pkg::dp_cmd_t            cmd,
  output logic [arpt_pkg::PCT_W-1:0]   out_percent,
  output logic                         out_range_invalid
);
  import arpt_pkg::*;

  localparam int SUM_W = VAL_W + $clog2(LIST_DEPTH);
  localparam int NUM_W = SUM_W + PCT_W;
  localparam logic [SUM_W-1:0] LOW_SUM_RST  = SUM_W'(LIST_DEPTH * int'(RESET_LOW));
  localparam logic [SUM_W-1:0] HIGH_SUM_RST = SUM_W'(LIST_DEPTH * int'(RESET_HIGH));

  logic [VAL_W-1:0] reject_r;
  logic [VAL_W-1:0] r_r, r_nxt;
  logic [VAL_W-1:0] low_r  [LIST_DEPTH];
  logic [VAL_W-1:0] high_r [LIST_DEPTH];
  logic [VAL_W-1:0] low_ins  [LIST_DEPTH];
  logic [VAL_W-1:0] high_ins [LIST_DEPTH];
  logic [SUM_W-1:0] sum_low_r, sum_high_r;
  logic [SUM_W-1:0] rn_r;
  logic             low_hit, high_hit;

  logic signed [SUM_W:0] scaled_r, den_r;
  logic [SUM_W-1:0]      abs_s;
  logic                  inv_r, pos_r, neg_r, sat_r;
  logic [NUM_W-1:0]      rem_r, trial;
  logic [PCT_W-1:0]      q_r, q_nxt;
  logic [PCT_W-1:0]      pct_sel;
  logic [PCT_W-1:0]      pct_r;
  logic                  inv_out_r;

  // clamp: negative to zero, bogus reading to smallest high entry
  always_comb begin
    r_nxt = in_reading[READ_W-1] ? '0 : in_reading[VAL_W-1:0];
    if (r_nxt > reject_r) begin
      r_nxt = high_r[0];
    end
  end

  assign low_hit  = r_r < low_r[LIST_DEPTH-1];
  assign high_hit = r_r > high_r[0];

  // parallel sorted insert; low list drops its largest, high its smallest
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_ins
    if (i == 0) begin : g_lo_first
      assign low_ins[i] = (low_r[i] <= r_r) ? low_r[i] : r_r;
    end else begin : g_lo_rest
      assign low_ins[i] = (low_r[i] <= r_r)   ? low_r[i] :
                          (low_r[i-1] <= r_r) ? r_r : low_r[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_hi_last
      assign high_ins[i] = (high_r[i] < r_r) ? r_r : high_r[i];
    end else begin : g_hi_rest
      assign high_ins[i] = (high_r[i+1] < r_r) ? high_r[i+1] :
                           (high_r[i] < r_r)   ? r_r : high_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reject_r   <= RESET_REJECT;
      sum_low_r  <= LOW_SUM_RST;
      sum_high_r <= HIGH_SUM_RST;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        low_r[i]  <= RESET_LOW;
        high_r[i] <= RESET_HIGH;
      end
    end else begin
      if (cfg_we) begin
        reject_r <= cfg_wdata;
      end
      if (cmd.update) begin
        if (low_hit) begin
          low_r     <= low_ins;
          sum_low_r <= sum_low_r - SUM_W'(low_r[LIST_DEPTH-1]) + SUM_W'(r_r);
        end
        if (high_hit) begin
          high_r     <= high_ins;
          sum_high_r <= sum_high_r - SUM_W'(high_r[0]) + SUM_W'(r_r);
        end
      end
    end
  end

  // magnitude of the scaled reading, sign taken straight from the difference
  assign abs_s = scaled_r[SUM_W] ? SUM_W'(-scaled_r) : SUM_W'(scaled_r);
  assign trial = NUM_W'(den_r[SUM_W-1:0]) << cmd.div_idx;

  always_comb begin
    q_nxt = q_r;
    q_nxt[cmd.div_idx] = 1'b1;
  end

  // final pick between divider result and the special cases
  always_comb begin
    if (inv_r) begin
      pct_sel = pos_r ? PCT_MAX : PCT_FLOOR;
    end else if (neg_r) begin
      pct_sel = (q_r != '0) ? PCT_FLOOR : PCT_ZERO;
    end else if (sat_r) begin
      pct_sel = PCT_MAX;
    end else begin
      pct_sel = q_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_r <= r_nxt;
    end
    if (cmd.update) begin
      rn_r <= SUM_W'(r_r) * SUM_W'(LIST_DEPTH);
    end
    if (cmd.diff) begin
      scaled_r <= $signed({1'b0, rn_r}) - $signed({1'b0, sum_low_r});
      den_r    <= $signed({1'b0, sum_high_r}) - $signed({1'b0, sum_low_r});
    end
    if (cmd.scale) begin
      inv_r <= den_r[SUM_W] | (den_r == '0);
      neg_r <= scaled_r[SUM_W];
      pos_r <= !scaled_r[SUM_W] && (scaled_r != '0);
      sat_r <= !scaled_r[SUM_W] && (scaled_r >= den_r);
      rem_r <= NUM_W'(abs_s) * NUM_W'(PCT_SCALE);
      q_r   <= '0;
    end
    if (cmd.div_step && (rem_r >= trial)) begin
      rem_r <= rem_r - trial;
      q_r   <= q_nxt;
    end
    if (cmd.out_load) begin
      pct_r     <= pct_sel;
      inv_out_r <= inv_r;
    end
  end

  assign out_percent       = pct_r;
  assign out_range_invalid = inv_out_r;

endmodule

// ===== rtl/auto_range_percent_tracker.sv =====
// ----------------------------------------------------------------------------
// auto_range_percent_tracker - percent position of a reading between the
// averages of the smallest and largest readings seen
// Keeps two sorted lists of LIST_DEPTH readings with running sums and
// reports ((reading*N - sum_low)*100)/(sum_high - sum_low), clamped to 0..99.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------
//  cfg       cfg_we               cfg_wdata (reject limit, 1/16 units)
//  in        in_valid / in_stall  in_reading (signed, 4 fraction bits)
//  out       out_valid/out_stall  out_percent, out_range_invalid
//
//  one reading passes from transfer to result in the output register
//  through capture, list update, difference, scale, seven divide steps
//  and the result load; in_stall stays high from capture until the result
//  load, so a new reading is taken only after the last one is loaded
//  reset (rst_n low, synchronous) loads the lists, sums and reject limit
//  a stalled output holds its result; the next reading is still taken and
//  waits in its last step until the output register empties
//
module auto_range_percent_tracker #(
  parameter int LIST_DEPTH = arpt_pkg::DEF_LIST_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write
  input  logic                               cfg_we,
  input  logic [arpt_pkg::VAL_W-1:0]         cfg_wdata,
  // reading input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [arpt_pkg::READ_W-1:0] in_reading,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [arpt_pkg::PCT_W-1:0]         out_percent,
  output logic                               out_range_invalid
);
  import arpt_pkg::*;

  // command bundle from the sequencer to the datapath
  dp_cmd_t cmd;

  // controller: owns handshake flags and the step sequence
  arpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: lists, sums, divider and the output payload register
  arpt_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_reading        (in_reading),
    .cmd               (cmd),
    .out_percent       (out_percent),
    .out_range_invalid (out_range_invalid)
  );

endmodule
